// File: rtl/core/ssd_pkg.sv
package ssd_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int POS_W       = 2;
    localparam int VALUE_W     = 14;

    localparam logic [7:0]         BLANK_BYTE    = 8'hFF;
    localparam logic [7:0]         DP_CLEAR_MASK = 8'h7F;
    localparam logic [7:0]         DP_BIT        = 8'h80;
    localparam logic [VALUE_W-1:0] NUMBER_LIMIT  = 14'd9999;

    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_NUMBER  = 3'd1,
        ACT_COUNTER = 3'd2,
        ACT_DIGIT   = 3'd3,
        ACT_SEGMENT = 3'd4,
        ACT_DP      = 3'd5,
        ACT_CLEAR   = 3'd6,
        ACT_DP_OFF  = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CONV = 2'b10
    } state_t;

    // request to the decimal conversion unit
    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] value;
    } bcd_cmd_t;

    // digits[0] is the thousands digit, digits[3] the units digit
    typedef struct packed {
        logic            done;
        logic [3:0][3:0] digits;
    } bcd_res_t;

    // active-low glyphs, bit order dp g f e d c b a
    function automatic logic [7:0] glyph(input logic [3:0] d);
        logic [7:0] g;
        unique case (d)
            4'd0:    g = 8'hC0;
            4'd1:    g = 8'hF9;
            4'd2:    g = 8'hA4;
            4'd3:    g = 8'hB0;
            4'd4:    g = 8'h99;
            4'd5:    g = 8'h92;
            4'd6:    g = 8'h82;
            4'd7:    g = 8'hF8;
            4'd8:    g = 8'h80;
            4'd9:    g = 8'h90;
            default: g = BLANK_BYTE;
        endcase
        return g;
    endfunction

endpackage

// File: rtl/core/ssd_bcd_unit.sv
module ssd_bcd_unit
    import ssd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  bcd_cmd_t cmd,
    output bcd_res_t res
);

    localparam logic [1:0] SEL_THOUSANDS = 2'd0;
    localparam logic [1:0] SEL_HUNDREDS  = 2'd1;
    localparam logic [1:0] SEL_TENS      = 2'd2;

    logic               active_reg, active_next;
    logic [1:0]         sel_reg, sel_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [VALUE_W-1:0] rem_reg, rem_next;
    logic [3:0]         d0_reg, d0_next;
    logic [3:0]         d1_reg, d1_next;

    logic [VALUE_W-1:0] weight;
    logic               ge;
    logic [VALUE_W-1:0] diff;
    logic               done;

    // one compare and subtract per cycle against the current decade weight
    always_comb
    begin
        unique case (sel_reg)
            SEL_THOUSANDS: weight = 14'd1000;
            SEL_HUNDREDS:  weight = 14'd100;
            default:       weight = 14'd10;
        endcase
    end

    assign ge   = (rem_reg >= weight);
    assign diff = rem_reg - weight;
    assign done = active_reg && !ge && (sel_reg == SEL_TENS);

    always_comb
    begin
        active_next = active_reg;
        sel_next    = sel_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        d0_next     = d0_reg;
        d1_next     = d1_reg;
        if (cmd.start)
        begin
            active_next = 1'b1;
            sel_next    = SEL_THOUSANDS;
            cnt_next    = 4'd0;
            rem_next    = cmd.value;
        end
        else if (active_reg)
        begin
            if (ge)
            begin
                rem_next = diff;
                cnt_next = cnt_reg + 4'd1;
            end
            else
            begin
                cnt_next = 4'd0;
                unique case (sel_reg)
                    SEL_THOUSANDS:
                    begin
                        d0_next  = cnt_reg;
                        sel_next = SEL_HUNDREDS;
                    end
                    SEL_HUNDREDS:
                    begin
                        d1_next  = cnt_reg;
                        sel_next = SEL_TENS;
                    end
                    default:
                    begin
                        active_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            sel_reg    <= SEL_THOUSANDS;
            cnt_reg    <= 4'd0;
        end
        else
        begin
            active_reg <= active_next;
            sel_reg    <= sel_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        d0_reg  <= d0_next;
        d1_reg  <= d1_next;
    end

    always_comb
    begin
        res.done      = done;
        res.digits[0] = d0_reg;
        res.digits[1] = d1_reg;
        res.digits[2] = cnt_reg;
        res.digits[3] = rem_reg[3:0];
    end

endmodule

// File: rtl/core/seven_segment_scan_controller_top.sv
// channel  | beat marker          | payload
// ---------+----------------------+-------------------------------------------------
// command  | start & !busy        | action, number_value, position, digit_value,
//          |                      | segment_pattern, flag_bit
// result   | strobe (one cycle)   | segment_byte, select_byte, digit_index
// config   | psel&penable&pwrite  | paddr, pwdata (select_mode at byte address 0)
//
// tick and single-position writes leave busy low
// number and counter writes run the decimal conversion unit, one compare and
// subtract per cycle, with busy high until the unit reports done
// reset (rst_n low, asynchronous) blanks all digits, zeroes the scan index and
// selects active-low digit drive
// the result beat appears the cycle after its tick and cannot be stalled
module seven_segment_scan_controller_top
    import ssd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // command channel
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           action,
    input  logic [15:0]          number_value,
    input  logic [POS_W-1:0]     position,
    input  logic [3:0]           digit_value,
    input  logic [7:0]           segment_pattern,
    input  logic                 flag_bit,
    // result channel
    output logic                 strobe,
    output logic [7:0]           segment_byte,
    output logic [7:0]           select_byte,
    output logic [POS_W-1:0]     digit_index,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    state_t               state_reg, state_next;
    logic [7:0]           seg_buf_reg [DIGIT_COUNT];
    logic [7:0]           seg_buf_next [DIGIT_COUNT];
    logic [POS_W-1:0]     scan_reg, scan_next;
    logic                 zeros_reg, zeros_next;
    logic                 select_mode_reg;
    logic                 strobe_reg, strobe_next;
    logic [7:0]           seg_out_reg, seg_out_next;
    logic [7:0]           sel_out_reg, sel_out_next;
    logic [POS_W-1:0]     idx_out_reg, idx_out_next;

    logic                 accept;
    logic                 cfg_write;
    action_t              act;
    logic [VALUE_W-1:0]   clamped;
    logic [7:0]           dp_mask;
    logic                 lead;
    bcd_cmd_t             bcd_cmd;
    bcd_res_t             bcd_res;

    // decimal conversion: shared compare/subtract unit
    ssd_bcd_unit u_bcd
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (bcd_cmd),
        .res   (bcd_res)
    );

    assign busy    = (state_reg == ST_CONV);
    assign accept  = start && !busy;
    assign act     = action_t'(action);
    assign clamped = (number_value > {2'b00, NUMBER_LIMIT}) ? NUMBER_LIMIT
                                                            : number_value[VALUE_W-1:0];
    // optional decimal point, cleared bit lights it
    assign dp_mask = flag_bit ? DP_CLEAR_MASK : BLANK_BYTE;

    always_comb
    begin
        state_next    = state_reg;
        seg_buf_next  = seg_buf_reg;
        scan_next     = scan_reg;
        zeros_next    = zeros_reg;
        strobe_next   = 1'b0;
        seg_out_next  = seg_out_reg;
        sel_out_next  = sel_out_reg;
        idx_out_next  = idx_out_reg;
        bcd_cmd.start = 1'b0;
        bcd_cmd.value = clamped;
        lead          = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (act)
                        ACT_TICK:
                        begin
                            strobe_next  = 1'b1;
                            seg_out_next = seg_buf_reg[scan_reg];
                            // active-high reversed order, or active-low in order
                            sel_out_next = select_mode_reg ? (8'h08 >> scan_reg)
                                                           : ~(8'h01 << scan_reg);
                            idx_out_next = scan_reg;
                            scan_next    = scan_reg + 2'd1;
                        end
                        ACT_NUMBER:
                        begin
                            bcd_cmd.start = 1'b1;
                            zeros_next    = flag_bit;
                            state_next    = ST_CONV;
                        end
                        ACT_COUNTER:
                        begin
                            // counter blanking matches number blanking without zeros
                            bcd_cmd.start = 1'b1;
                            bcd_cmd.value = {{(VALUE_W-5){1'b0}}, number_value[4:0]};
                            zeros_next    = 1'b0;
                            state_next    = ST_CONV;
                        end
                        ACT_DIGIT:
                        begin
                            if (digit_value <= 4'd9)
                                seg_buf_next[position] = glyph(digit_value) & dp_mask;
                        end
                        ACT_SEGMENT:
                        begin
                            seg_buf_next[position] = segment_pattern & dp_mask;
                        end
                        ACT_DP:
                        begin
                            if (flag_bit)
                                seg_buf_next[position] = seg_buf_reg[position] & DP_CLEAR_MASK;
                            else
                                seg_buf_next[position] = seg_buf_reg[position] | DP_BIT;
                        end
                        ACT_CLEAR:
                        begin
                            for (int p = 0; p < DIGIT_COUNT; p++)
                                seg_buf_next[p] = BLANK_BYTE;
                        end
                        ACT_DP_OFF:
                        begin
                            for (int p = 0; p < DIGIT_COUNT; p++)
                                seg_buf_next[p] = seg_buf_reg[p] | DP_BIT;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                if (bcd_res.done)
                begin
                    // leading zeros blank unless asked for; units digit always shown
                    for (int p = 0; p < DIGIT_COUNT - 1; p++)
                    begin
                        lead = lead && (bcd_res.digits[p] == 4'd0);
                        seg_buf_next[p] = (lead && !zeros_reg) ? BLANK_BYTE
                                                               : glyph(bcd_res.digits[p]);
                    end
                    seg_buf_next[DIGIT_COUNT-1] = glyph(bcd_res.digits[DIGIT_COUNT-1]);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            scan_reg   <= '0;
            strobe_reg <= 1'b0;
            zeros_reg  <= 1'b0;
            for (int p = 0; p < DIGIT_COUNT; p++)
                seg_buf_reg[p] <= BLANK_BYTE;
        end
        else
        begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            strobe_reg   <= strobe_next;
            zeros_reg    <= zeros_next;
            seg_buf_reg  <= seg_buf_next;
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        seg_out_reg <= seg_out_next;
        sel_out_reg <= sel_out_next;
        idx_out_reg <= idx_out_next;
    end

    // configuration register, one word at byte address 0
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            select_mode_reg <= 1'b0;
        else if (cfg_write && (paddr[2] == 1'b0))
            select_mode_reg <= pwdata[0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'b0, select_mode_reg} : 32'b0;

    assign strobe       = strobe_reg;
    assign segment_byte = seg_out_reg;
    assign select_byte  = sel_out_reg;
    assign digit_index  = idx_out_reg;

    // a result beat only follows an accepted tick
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(start && !busy && (action == ACT_TICK)))
    else $error("result beat without a tick");

    // a tick leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !busy)
    else $error("busy after a tick");

    // exactly one digit driven, in either polarity
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ($onehot(select_byte) || $onehot(~select_byte)))
    else $error("select byte not one-hot");

    // conversion only ends when the shared unit reports done
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(bcd_res.done))
    else $error("conversion ended early");

endmodule
